FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      shift;
    byte_src_t src;
    logic      count_inc;
    logic      count_clr;
    logic      comp_start;
    logic      round_en;
    logic      add_en;
    logic      emit_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       emit_last;
  } dp_stat_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [5:0] LEN_START     = 6'd56;
  localparam logic [5:0] ROUND_LAST    = 6'd63;
  localparam logic [2:0] WORD_LAST     = 3'd7;

  localparam logic [31:0] INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: hw/rtl/sha_datapath.sv
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::dp_cmd_t cmd,
  input  logic [7:0]       in_byte,
  output sha_pkg::dp_stat_t stat,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             final_word
);
  import sha_pkg::*;

  // Block window: first byte / oldest schedule word in the top bits.
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [60:0]  byte_count;
  logic [5:0]   round;
  logic [2:0]   idx;
  logic [31:0]  hash [8];
  logic [31:0]  wv [8];

  logic [63:0]  bit_len;
  logic [7:0]   pad_byte;
  logic [31:0]  w16, w15, w7, w2, sched_w;
  logic [31:0]  t1, t2, ch, maj;

  assign bit_len = {byte_count, 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_INPUT: pad_byte = in_byte;
      SRC_MARK:  pad_byte = PAD_MARK_BYTE;
      SRC_ZERO:  pad_byte = 8'h00;
      SRC_LEN:   pad_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
      default:   pad_byte = 8'h00;
    endcase
  end

  assign w16 = blk[511:480];
  assign w15 = blk[479:448];
  assign w7  = blk[223:192];
  assign w2  = blk[63:32];
  // First sixteen rounds rotate the loaded words through the window.
  assign sched_w = (round[5:4] == 2'b00) ? w16
                 : small_sigma1(w2) + w7 + small_sigma0(w15) + w16;

  assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1  = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[round] + sched_w;
  assign t2  = big_sigma0(wv[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[503:0], pad_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], sched_w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      byte_count <= '0;
      round      <= '0;
      idx        <= '0;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_clr) begin
        byte_count <= '0;
      end else if (cmd.count_inc) begin
        byte_count <= byte_count + 61'd1;
      end
      if (cmd.comp_start) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 6'd1;
      end
      if (cmd.emit_shift) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int j = 0; j < 8; j++) begin
        wv[j] <= hash[j];
      end
    end else if (cmd.round_en) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  // Emit by shifting the chain toward word 0; refill from the initial values.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) begin
        hash[j] <= INIT_HASH[j];
      end
    end else if (cmd.add_en) begin
      for (int j = 0; j < 8; j++) begin
        hash[j] <= hash[j] + wv[j];
      end
    end else if (cmd.emit_shift) begin
      for (int j = 0; j < 7; j++) begin
        hash[j] <= hash[j+1];
      end
      hash[7] <= INIT_HASH[idx];
    end
  end

  assign stat.fill       = fill;
  assign stat.round_last = (round == ROUND_LAST);
  assign stat.emit_last  = (idx == WORD_LAST);

  assign digest_word = hash[0];
  assign word_index  = idx;
  assign final_word  = (idx == WORD_LAST);

endmodule

FILE: hw/rtl/sha_ctrl.sv
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_present,
  input  logic              in_last,
  input  logic              out_ready,
  input  sha_pkg::dp_stat_t stat,
  output sha_pkg::dp_cmd_t  cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import sha_pkg::*;

  ctl_state_t state, state_next;
  ctl_state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    cmd.src    = SRC_INPUT;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_present) begin
            cmd.shift     = 1'b1;
            cmd.count_inc = 1'b1;
          end
          if (in_present && stat.fill == FILL_LAST) begin
            cmd.comp_start = 1'b1;
            state_next     = ST_ROUND;
            ret_next       = in_last ? ST_PAD_MARK : ST_IDLE;
          end else if (in_last) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
        state_next = ret;
      end
      ST_PAD_MARK: begin
        cmd.shift = 1'b1;
        cmd.src   = SRC_MARK;
        if (stat.fill == FILL_LAST) begin
          cmd.comp_start = 1'b1;
          state_next     = ST_ROUND;
          ret_next       = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (stat.fill == LEN_START) begin
          state_next = ST_PAD_LEN;
        end else begin
          cmd.shift = 1'b1;
          cmd.src   = SRC_ZERO;
          if (stat.fill == FILL_LAST) begin
            cmd.comp_start = 1'b1;
            state_next     = ST_ROUND;
            ret_next       = ST_PAD_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd.shift = 1'b1;
        cmd.src   = SRC_LEN;
        if (stat.fill == FILL_LAST) begin
          cmd.comp_start = 1'b1;
          state_next     = ST_ROUND;
          ret_next       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_shift = 1'b1;
          if (stat.emit_last) begin
            cmd.count_clr = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/sha256_message_hasher_top.sv
// SHA-256 message hasher. Feed the message one byte per word on the slave
// stream (s_tuser = 1 when s_tdata carries a message byte, s_tlast = 1 on
// the word that ends the message; s_tuser = 0 with s_tlast = 1 ends a
// message without adding a byte, which also hashes the empty message).
// After the last word the block pads the message, finishes the digest and
// emits eight 32-bit digest words H0..H7 on the master stream, word index in
// m_tuser and m_tlast on H7; it then starts a fresh message. The message
// length counts modulo 2^61 bytes. A byte word is taken whenever the block
// is idle; the word that completes a 64-byte block starts a compression of
// 64 rounds at one round per cycle, then a fold of the result into the
// chaining value, during which s_tready stays low. The end of a message
// writes the padding bytes one at a time up to the block end, pausing once
// just before the length bytes, then runs one or two compressions and
// emits eight output words; the shared round unit and the byte-serial block
// window set this pace. The block takes no new word while a digest is
// pending.
module sha256_message_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] message_byte
  input  logic [0:0]  s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // final_word
);
  import sha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the block fill, padding, rounds and digest output.
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_present (s_tuser[0]),
    .in_last    (s_tlast),
    .out_ready  (m_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid)
  );

  // Hold the block window, length count, round state and chaining value.
  sha_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_byte     (s_tdata),
    .stat        (stat),
    .digest_word (m_tdata),
    .word_index  (m_tuser),
    .final_word  (m_tlast)
  );

endmodule

FILE: hw/rtl/sha_checker.sv
`include "assert_macros.svh"

module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // Input is never taken while a digest word is pending.
  `ASSERT_SAME(a_no_overlap, clk, rst, m_tvalid, !s_tready)

  // The eighth word carries the end marker and no other does.
  `ASSERT_SAME(a_last_index, clk, rst, m_tvalid, m_tlast == (m_tuser == 3'd7))

  // Words of one digest come back to back in index order.
  `ASSERT_NEXT(a_index_step, clk, rst, m_tvalid && m_tready && !m_tlast,
               m_tvalid && m_tuser == 3'($past(m_tuser) + 3'd1))

  // The digest ends cleanly and the block is ready for a new message.
  `ASSERT_NEXT(a_end_idle, clk, rst, m_tvalid && m_tready && m_tlast,
               !m_tvalid && s_tready)

  // A stalled word holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: tb/sv/sha256_digest_pkg.sv
`timescale 1ns / 1ps

package sha256_digest_pkg;

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam int         LEN_FIELD_BYTE = 56;
  localparam int         LAST_WORD_IDX  = 7;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  index;
    logic        is_last;
  } digest_word_t;

  class digest_tracker;
    logic [31:0]  chain [8];
    logic [7:0]   block_bytes [64];
    logic [60:0]  byte_total;
    digest_word_t digest_due [$];
    int           errors;

    function new();
      chain      = START_HASH;
      byte_total = '0;
      errors     = 0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64-byte block into the chaining value, schedule in a 16-word window.
    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] sched, t1, t2, w2, w15;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      v = chain;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          sched = w[t];
        end else begin
          w2  = w[(t - 2) % 16];
          w15 = w[(t - 15) % 16];
          sched = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + w[(t - 7) % 16] +
                  (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + w[t % 16];
          w[t % 16] = sched;
        end
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched;
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
        chain[i] = chain[i] + v[i];
    endfunction

    // Note one accepted input word; on the end of a message, pad and queue the digest.
    function void take_byte_word(logic [7:0] data, logic present, logic ends);
      int          fill;
      logic [63:0] bit_len;
      if (present) begin
        block_bytes[byte_total[5:0]] = data;
        byte_total = byte_total + 1'b1;
        if (byte_total[5:0] == 6'd0)
          compress();
      end
      if (!ends)
        return;
      fill    = int'(byte_total[5:0]);
      bit_len = {byte_total, 3'b000};
      block_bytes[fill] = PAD_MARK;
      for (int i = fill + 1; i < 64; i++)
        block_bytes[i] = 8'h00;
      // no room left for the length: spill it into a second block
      if (fill >= LEN_FIELD_BYTE) begin
        compress();
        foreach (block_bytes[i])
          block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++)
        block_bytes[LEN_FIELD_BYTE + i] = bit_len[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++)
        digest_due.push_back('{chain[i], 3'(i), i == LAST_WORD_IDX});
      chain      = START_HASH;
      byte_total = '0;
    endfunction

    function void check_digest_word(logic [31:0] value, logic [2:0] index, logic is_last);
      digest_word_t want;
      if (digest_due.size() == 0) begin
        $error("digest word %h (word_index %0d) arrived with no digest pending", value, index);
        errors++;
        return;
      end
      want = digest_due.pop_front();
      if (value !== want.value) begin
        $error("digest_word: expected %h, got %h", want.value, value);
        errors++;
      end
      if (index !== want.index) begin
        $error("word_index: expected %0d, got %0d", want.index, index);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("final_word: expected %0b, got %0b", want.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return digest_due.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/sha256_message_hasher_top_tb.sv
`timescale 1ns / 1ps

module sha256_message_hasher_top_tb;
  import sha256_digest_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] message_byte
  logic [0:0]  s_tuser;   // [0] byte_present
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic [2:0]  m_tuser;   // [2:0] word_index
  logic        m_tlast;   // final_word

  // Idle odds in percent, set per phase by the stimulus process.
  int send_idle_pct;
  int recv_stall_pct;
  // Raised by the stimulus to have the receiver hold off for a long stretch.
  bit hold_request;

  digest_tracker hasher;

  sha256_message_hasher_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Offer one word; drive at the falling edge, wait for the handshake at the
  // rising edge. Leave tvalid high so a following word goes out back to back.
  task automatic send_word(input logic [7:0] data, input logic present, input logic ends);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    hasher.take_byte_word(data, present, ends);
  endtask

  // Send a message of random bytes. Sprinkle in absent, non-final words the
  // block must ignore, and end either on the last byte or with an empty
  // terminator word; end_on_byte forces the end onto the last byte.
  task automatic send_message(input int len, input bit end_on_byte = 1'b0);
    bit split_end;
    split_end = (len == 0) || (!end_on_byte && $urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, !split_end && i == len - 1);
    end
    if (split_end)
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Drop tvalid and hold the sender until every pending digest word is out.
  task automatic wait_digests_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (hasher.pending() != 0)
      @(posedge clk);
  endtask

  // Receiver: stall at random, or hold off for a long counted stretch on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every digest word accepted at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        hasher.check_digest_word(m_tdata, m_tuser, m_tlast);
    end
  end

  // Stimulus.
  initial begin
    int phase_items;
    int msg_num;
    int len;
    hasher         = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    s_tlast        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message: terminator word with no byte; its data must be ignored.
    send_word(8'hA5, 1'b0, 1'b1);
    // Absent byte without last: the block must not change anything.
    send_word(8'h3C, 1'b0, 1'b0);
    // "abc", last on the final byte.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // Top byte value, then an empty terminator.
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // Zero byte carrying last.
    send_word(8'h00, 1'b1, 1'b1);
    // Ignored word inside a message.
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'h7F, 1'b1, 1'b1);
    wait_digests_drained();

    // Hold the receiver off while two messages go in: the first digest
    // backs up and the block must stall its input for the second.
    hold_request = 1'b1;
    send_message(3);
    send_message(2);
    wait_digests_drained();

    // Random messages over four idle phases: none, sender idle, receiver
    // stalled, both lightly. Force one message that fills a block on its last
    // byte and one that needs a second padding block.
    msg_num = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      phase_items = 0;
      while (phase_items < 32) begin
        msg_num++;
        if (msg_num == 2)
          len = 64;
        else if (msg_num == 7)
          len = 56;
        else if ($urandom_range(9) == 0)
          case ($urandom_range(3))
            0:       len = 55;
            1:       len = 57;
            2:       len = 63;
            default: len = 65;
          endcase
        else
          len = $urandom_range(9);
        send_message(len, msg_num == 2);
        phase_items += len + 1;
      end
      wait_digests_drained();
    end

    // Let any stray output show up before the verdict.
    repeat (50) @(posedge clk);
    if (hasher.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
